[hdl/bspq_pkg.sv]
package bspq_pkg;

   localparam int TAG_W     = 8;
   localparam int PRIO_W    = 16;
   localparam int PAYLOAD_W = 32;
   localparam int CAP_W     = 5;
   localparam int COUNT_W   = 5;

   // Request operation codes
   typedef enum logic {
      OP_PUT = 1'b0,
      OP_GET = 1'b1
   } op_type;

   // Completion kinds
   typedef enum logic [1:0] {
      KIND_PUT_DONE = 2'd0,
      KIND_GET_DONE = 2'd1,
      KIND_REJECT   = 2'd2
   } done_kind_type;

   // One stored entry
   typedef struct packed {
      logic signed [PRIO_W-1:0] prio;
      logic [PAYLOAD_W-1:0]     payload;
   } entry_type;

   // One put waiting for room in the store
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      entry_type        entry;
   } waiter_put_type;

   // One completion held for the response channel
   typedef struct packed {
      logic [TAG_W-1:0]     tag;
      done_kind_type        kind;
      logic [PAYLOAD_W-1:0] payload;
   } result_type;

   // Commands from the controller to the sorted store
   typedef struct packed {
      logic      insert;
      logic      take;
      entry_type entry;
   } store_cmd_type;

   // Status back from the sorted store
   typedef struct packed {
      logic                 done;
      logic [PAYLOAD_W-1:0] taken_payload;
   } store_sts_type;

   typedef enum logic [1:0] {
      STO_IDLE,
      STO_INS_RD,
      STO_INS_CMP,
      STO_TAKE_DATA
   } store_state_type;

   typedef enum logic [3:0] {
      CTL_IDLE,
      CTL_DECIDE,
      CTL_PUT_WAIT,
      CTL_SERVE,
      CTL_SERVE_WAIT,
      CTL_GET_WAIT,
      CTL_REFILL,
      CTL_REFILL_WAIT,
      CTL_OUT
   } ctl_state_type;

endpackage

[hdl/bspq_if.sv]
// Request channel
interface bspq_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     operation;
   logic [bspq_pkg::TAG_W-1:0]               requester_tag;
   logic signed [bspq_pkg::PRIO_W-1:0]       entry_priority;
   logic [bspq_pkg::PAYLOAD_W-1:0]           entry_payload;

   modport source (output valid, operation, requester_tag, entry_priority, entry_payload,
                   input ready);
   modport sink   (input valid, operation, requester_tag, entry_priority, entry_payload,
                   output ready);
endinterface

// Completion channel
interface bspq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bspq_pkg::TAG_W-1:0]       done_tag;
   logic [1:0]                       done_kind;
   logic [bspq_pkg::PAYLOAD_W-1:0]   delivered_payload;
   logic [bspq_pkg::COUNT_W-1:0]     stored_count;
   logic                             last_of_run;

   modport source (output valid, done_tag, done_kind, delivered_payload, stored_count,
                   last_of_run, input ready);
   modport sink   (input valid, done_tag, done_kind, delivered_payload, stored_count,
                   last_of_run, output ready);
endinterface

// Capacity register write channel
interface bspq_csr_if;
   logic                         valid;
   logic                         ready;
   logic [bspq_pkg::CAP_W-1:0]   capacity_limit;

   modport source (output valid, capacity_limit, input ready);
   modport sink   (input valid, capacity_limit, output ready);
endinterface

[hdl/bspq_ram.sv]
module bspq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/bspq_fifo.sv]
module bspq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic [CW-1:0]    count
);

   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;

   // ring pointers; head is read every cycle, so head_data is registered and trails the head pointer by one register
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + AW'(1);
      end
      if (pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   bspq_ram #(
      .WIDTH (WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (push_data),
      .rd_addr (head_ff),
      .rd_data (head_data)
   );

   assign count = count_ff;

endmodule

[hdl/bspq_store.sv]
module bspq_store #(
   parameter int STORE_DEPTH = 16,
   localparam int AW = $clog2(STORE_DEPTH),
   localparam int CW = $clog2(STORE_DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bspq_pkg::store_cmd_type cmd,
   output bspq_pkg::store_sts_type sts,
   output logic [CW-1:0]           count
);

   localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(STORE_DEPTH);
   localparam logic [AW-1:0] LAST_PTR = AW'(STORE_DEPTH - 1);

   bspq_pkg::store_state_type state_ff, state_in;
   logic [AW-1:0]             head_ff, head_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [AW-1:0]             idx_ff, idx_in;
   bspq_pkg::entry_type       ins_ff, ins_in;

   logic [AW:0]               phys_sum;
   logic [AW-1:0]             phys_cur;
   logic [AW-1:0]             phys_prev;
   logic [AW-1:0]             head_next;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [AW-1:0]             rd_addr;
   bspq_pkg::entry_type       wr_entry;
   bspq_pkg::entry_type       rd_entry;
   logic [$bits(bspq_pkg::entry_type)-1:0] rd_raw;

   // circular store: logical slot idx lives at head + idx
   always_comb begin
      phys_sum  = {1'b0, head_ff} + {1'b0, idx_ff};
      phys_cur  = (phys_sum >= DEPTH_W) ? AW'(phys_sum - DEPTH_W) : phys_sum[AW-1:0];
      phys_prev = (phys_cur == '0) ? LAST_PTR : phys_cur - AW'(1);
      head_next = (head_ff == LAST_PTR) ? '0 : head_ff + AW'(1);
   end

   assign rd_entry = bspq_pkg::entry_type'(rd_raw);

   // insertion walks down from the tail, one compare per visited entry
   always_comb begin
      state_in          = state_ff;
      head_in           = head_ff;
      count_in          = count_ff;
      idx_in            = idx_ff;
      ins_in            = ins_ff;
      wr_en             = 1'b0;
      wr_addr           = phys_cur;
      wr_entry          = ins_ff;
      rd_addr           = phys_prev;
      sts.done          = 1'b0;
      sts.taken_payload = rd_entry.payload;
      unique case (state_ff)
         bspq_pkg::STO_IDLE: begin
            if (cmd.insert) begin
               ins_in   = cmd.entry;
               idx_in   = count_ff[AW-1:0];
               state_in = bspq_pkg::STO_INS_RD;
            end else if (cmd.take) begin
               rd_addr  = head_ff;
               state_in = bspq_pkg::STO_TAKE_DATA;
            end
         end
         bspq_pkg::STO_INS_RD: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               sts.done = 1'b1;
               state_in = bspq_pkg::STO_IDLE;
            end else begin
               state_in = bspq_pkg::STO_INS_CMP;
            end
         end
         bspq_pkg::STO_INS_CMP: begin
            // strictly greater moves up, so equal priorities keep arrival order
            wr_en = 1'b1;
            if ($signed(rd_entry.prio) > $signed(ins_ff.prio)) begin
               wr_entry = rd_entry;
               idx_in   = idx_ff - AW'(1);
               state_in = bspq_pkg::STO_INS_RD;
            end else begin
               count_in = count_ff + CW'(1);
               sts.done = 1'b1;
               state_in = bspq_pkg::STO_IDLE;
            end
         end
         bspq_pkg::STO_TAKE_DATA: begin
            head_in  = head_next;
            count_in = count_ff - CW'(1);
            sts.done = 1'b1;
            state_in = bspq_pkg::STO_IDLE;
         end
         default: begin
            state_in = bspq_pkg::STO_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bspq_pkg::STO_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      ins_ff <= ins_in;
   end

   bspq_ram #(
      .WIDTH ($bits(bspq_pkg::entry_type)),
      .DEPTH (STORE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign count = count_ff;

endmodule

[hdl/blocking_stable_priority_queue.sv]
// Sorted priority queue with blocking put and get.
// req_ch carries one request: operation (put/get), requester_tag, and for a put
// entry_priority (signed, lower served first) and entry_payload. rsp_ch returns
// completions: done_tag, done_kind (put done, get done, reject), delivered_payload,
// stored_count after the request, and last_of_run on the final one of a request.
// A request gives zero, one or two completions; one that has to wait gives none
// now and completes later as the second completion of some other request.
// csr_ch writes capacity_limit (0 = full store depth); write it while idle.
// One request at a time: req_ch.ready is high only while idle. A put inserts its
// entry by a walk in the store's RAM that moves each stored entry of higher priority
// up one place, one compare per visited entry. A put that finds a waiting get then
// hands the front entry over to the oldest one. A get takes the front entry, and the
// oldest waiting put then refills the store by the same walk. The completions then go
// out on rsp_ch in order; a new request is taken from the cycle after the last one.
// A stalled rsp_ch holds the completion and the block takes no new request.
// Reset empties the store and both waiter queues and clears capacity_limit.
module blocking_stable_priority_queue #(
   parameter int STORE_DEPTH  = 16,
   parameter int WAITER_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   bspq_req_if.sink   req_ch,
   bspq_rsp_if.source rsp_ch,
   bspq_csr_if.sink   csr_ch
);

   localparam int SCW   = $clog2(STORE_DEPTH + 1);
   localparam int WCW   = $clog2(WAITER_DEPTH + 1);
   localparam int CMP_W = 10;
   localparam logic [SCW-1:0] STORE_FULL  = SCW'(STORE_DEPTH);
   localparam logic [WCW-1:0] WAITER_FULL = WCW'(WAITER_DEPTH);

   bspq_pkg::ctl_state_type      state_ff, state_in;
   logic [bspq_pkg::CAP_W-1:0]   cap_ff;
   bspq_pkg::op_type             op_ff;
   logic [bspq_pkg::TAG_W-1:0]   tag_ff;
   bspq_pkg::entry_type          entry_ff;
   bspq_pkg::result_type         res_ff [2];
   bspq_pkg::result_type         res_in [2];
   logic                         two_ff, two_in;
   logic                         out_idx_ff, out_idx_in;

   bspq_pkg::store_cmd_type      scmd;
   bspq_pkg::store_sts_type      ssts;
   logic [SCW-1:0]               store_count;

   logic                         wget_push, wget_pop;
   logic [bspq_pkg::TAG_W-1:0]   wget_head;
   logic [WCW-1:0]               wget_count;
   logic                         wput_push, wput_pop;
   bspq_pkg::waiter_put_type     wput_new;
   logic [$bits(bspq_pkg::waiter_put_type)-1:0] wput_raw;
   bspq_pkg::waiter_put_type     wput_head;
   logic [WCW-1:0]               wput_count;

   logic                         cap_is_depth;
   logic                         put_blocked;
   logic                         req_fire;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign wput_head = bspq_pkg::waiter_put_type'(wput_raw);
   assign wput_new  = '{tag: tag_ff, entry: entry_ff};

   // capacity check: zero or above the depth means the whole store
   always_comb begin
      cap_is_depth = (cap_ff == '0) || (CMP_W'(cap_ff) > CMP_W'(STORE_DEPTH));
      put_blocked  = cap_is_depth ? (store_count == STORE_FULL)
                                  : (CMP_W'(store_count) >= CMP_W'(cap_ff));
   end

   // control sequencer
   always_comb begin
      state_in    = state_ff;
      res_in[0]   = res_ff[0];
      res_in[1]   = res_ff[1];
      two_in      = two_ff;
      out_idx_in  = out_idx_ff;
      scmd        = '0;
      wget_push   = 1'b0;
      wget_pop    = 1'b0;
      wput_push   = 1'b0;
      wput_pop    = 1'b0;
      unique case (state_ff)
         bspq_pkg::CTL_IDLE: begin
            out_idx_in = 1'b0;
            if (req_ch.valid) begin
               state_in = bspq_pkg::CTL_DECIDE;
            end
         end
         bspq_pkg::CTL_DECIDE: begin
            two_in = 1'b0;
            if (op_ff == bspq_pkg::OP_PUT) begin
               if (!put_blocked) begin
                  scmd.insert = 1'b1;
                  scmd.entry  = entry_ff;
                  res_in[0]   = '{tag: tag_ff, kind: bspq_pkg::KIND_PUT_DONE, payload: '0};
                  state_in    = bspq_pkg::CTL_PUT_WAIT;
               end else if (wput_count == WAITER_FULL) begin
                  res_in[0] = '{tag: tag_ff, kind: bspq_pkg::KIND_REJECT, payload: '0};
                  state_in  = bspq_pkg::CTL_OUT;
               end else begin
                  wput_push = 1'b1;
                  state_in  = bspq_pkg::CTL_IDLE;
               end
            end else begin
               if (store_count != '0) begin
                  scmd.take = 1'b1;
                  res_in[0] = '{tag: tag_ff, kind: bspq_pkg::KIND_GET_DONE, payload: '0};
                  state_in  = bspq_pkg::CTL_GET_WAIT;
               end else if (wget_count == WAITER_FULL) begin
                  res_in[0] = '{tag: tag_ff, kind: bspq_pkg::KIND_REJECT, payload: '0};
                  state_in  = bspq_pkg::CTL_OUT;
               end else begin
                  wget_push = 1'b1;
                  state_in  = bspq_pkg::CTL_IDLE;
               end
            end
         end
         bspq_pkg::CTL_PUT_WAIT: begin
            if (ssts.done) begin
               state_in = (wget_count != '0) ? bspq_pkg::CTL_SERVE : bspq_pkg::CTL_OUT;
            end
         end
         bspq_pkg::CTL_SERVE: begin
            scmd.take = 1'b1;
            state_in  = bspq_pkg::CTL_SERVE_WAIT;
         end
         bspq_pkg::CTL_SERVE_WAIT: begin
            // oldest waiting get takes the lowest entry
            if (ssts.done) begin
               res_in[1] = '{tag: wget_head, kind: bspq_pkg::KIND_GET_DONE,
                             payload: ssts.taken_payload};
               two_in    = 1'b1;
               wget_pop  = 1'b1;
               state_in  = bspq_pkg::CTL_OUT;
            end
         end
         bspq_pkg::CTL_GET_WAIT: begin
            if (ssts.done) begin
               res_in[0].payload = ssts.taken_payload;
               state_in = (wput_count != '0) ? bspq_pkg::CTL_REFILL : bspq_pkg::CTL_OUT;
            end
         end
         bspq_pkg::CTL_REFILL: begin
            // oldest waiting put moves into the freed place
            scmd.insert = 1'b1;
            scmd.entry  = wput_head.entry;
            res_in[1]   = '{tag: wput_head.tag, kind: bspq_pkg::KIND_PUT_DONE, payload: '0};
            two_in      = 1'b1;
            wput_pop    = 1'b1;
            state_in    = bspq_pkg::CTL_REFILL_WAIT;
         end
         bspq_pkg::CTL_REFILL_WAIT: begin
            if (ssts.done) begin
               state_in = bspq_pkg::CTL_OUT;
            end
         end
         bspq_pkg::CTL_OUT: begin
            if (rsp_ch.ready) begin
               if (out_idx_ff == two_ff) begin
                  state_in = bspq_pkg::CTL_IDLE;
               end else begin
                  out_idx_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = bspq_pkg::CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bspq_pkg::CTL_IDLE;
         cap_ff     <= '0;
         out_idx_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_idx_ff <= out_idx_in;
         if (csr_ch.valid && csr_ch.ready) begin
            cap_ff <= csr_ch.capacity_limit;
         end
      end
   end

   // request capture and completion slots
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= bspq_pkg::op_type'(req_ch.operation);
         tag_ff   <= req_ch.requester_tag;
         entry_ff <= '{prio: req_ch.entry_priority, payload: req_ch.entry_payload};
      end
      res_ff[0] <= res_in[0];
      res_ff[1] <= res_in[1];
      two_ff    <= two_in;
   end

   bspq_store #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (scmd),
      .sts   (ssts),
      .count (store_count)
   );

   bspq_fifo #(
      .WIDTH (bspq_pkg::TAG_W),
      .DEPTH (WAITER_DEPTH)
   ) u_wait_get (
      .clock     (clock),
      .reset     (reset),
      .push      (wget_push),
      .push_data (tag_ff),
      .pop       (wget_pop),
      .head_data (wget_head),
      .count     (wget_count)
   );

   bspq_fifo #(
      .WIDTH ($bits(bspq_pkg::waiter_put_type)),
      .DEPTH (WAITER_DEPTH)
   ) u_wait_put (
      .clock     (clock),
      .reset     (reset),
      .push      (wput_push),
      .push_data (wput_new),
      .pop       (wput_pop),
      .head_data (wput_raw),
      .count     (wput_count)
   );

   // ports
   assign req_ch.ready              = (state_ff == bspq_pkg::CTL_IDLE);
   assign csr_ch.ready              = 1'b1;
   assign rsp_ch.valid              = (state_ff == bspq_pkg::CTL_OUT);
   assign rsp_ch.done_tag           = res_ff[out_idx_ff].tag;
   assign rsp_ch.done_kind          = res_ff[out_idx_ff].kind;
   assign rsp_ch.delivered_payload  = res_ff[out_idx_ff].payload;
   assign rsp_ch.stored_count       = bspq_pkg::COUNT_W'(store_count);
   assign rsp_ch.last_of_run        = (out_idx_ff == two_ff);

   // between requests, gets wait only on an empty store
   a_gets_wait_on_empty: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == bspq_pkg::CTL_IDLE) && (wget_count != '0)) |-> (store_count == '0))
      else $error("waiting gets with a non-empty store");

   // between requests, puts wait only while the store holds entries
   a_puts_wait_on_nonempty: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == bspq_pkg::CTL_IDLE) && (wput_count != '0)) |-> (store_count != '0))
      else $error("waiting puts with an empty store");

   // store never overfills
   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      (CMP_W'(store_count) <= CMP_W'(STORE_DEPTH)))
      else $error("store count above depth");

   // no new request while a completion is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("request taken while completion pending");

endmodule

[test/blocking_stable_priority_queue_tb.sv]
`timescale 1ns / 1ps

module blocking_stable_priority_queue_tb;

   localparam int STORE_DEPTH   = 16;
   localparam int WAITER_DEPTH  = 16;
   localparam int RANDOM_ITEMS  = 433;
   localparam int IDLE_SETTLE   = 100;
   localparam int WATCHDOG_MAX  = 4000;

   localparam int TAG_W     = bspq_pkg::TAG_W;
   localparam int PRIO_W    = bspq_pkg::PRIO_W;
   localparam int PAYLOAD_W = bspq_pkg::PAYLOAD_W;
   localparam int CAP_W     = bspq_pkg::CAP_W;
   localparam int COUNT_W   = bspq_pkg::COUNT_W;

   // One completion as the response channel shows it
   typedef struct packed {
      logic [TAG_W-1:0]        tag;
      bspq_pkg::done_kind_type kind;
      logic [PAYLOAD_W-1:0]    payload;
      logic [COUNT_W-1:0]      count;
      logic                    last;
   } completion_type;

   // Directed stimulus rows
   typedef enum {ROW_REQ, ROW_FIXED, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      bspq_pkg::op_type        op;
      logic [TAG_W-1:0]        tag;
      int                      prio;
      int                      prio_step;
      logic [PAYLOAD_W-1:0]    payload;
      int                      reps;
      bspq_pkg::done_kind_type exp_kind;
      logic [COUNT_W-1:0]      exp_count;
   } stim_row_type;

   logic clock;
   logic reset;

   bspq_req_if req_ch ();
   bspq_rsp_if rsp_ch ();
   bspq_csr_if csr_ch ();

   blocking_stable_priority_queue #(
      .STORE_DEPTH  (STORE_DEPTH),
      .WAITER_DEPTH (WAITER_DEPTH)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // Predicted queue state
   bspq_pkg::entry_type      sorted_store[$];
   logic [TAG_W-1:0]         parked_gets[$];
   bspq_pkg::waiter_put_type parked_puts[$];
   logic [CAP_W-1:0]         capacity_reg = '0;

   completion_type step_results[$];
   completion_type pending_completions[$];
   stim_row_type   stim_table[$];

   logic           fixed_active = 1'b0;
   completion_type fixed_exp;
   logic           rsp_steady = 1'b0;
   logic           req_steady = 1'b0;
   int             error_count = 0;
   int             idle_cycles = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void note_completion(input logic [TAG_W-1:0] tag,
                                           input bspq_pkg::done_kind_type kind,
                                           input logic [PAYLOAD_W-1:0] payload);
      completion_type c;
      c.tag     = tag;
      c.kind    = kind;
      c.payload = payload;
      c.count   = '0;
      c.last    = 1'b0;
      step_results.push_back(c);
   endfunction

   // Equal priorities go after the ones already stored
   function automatic void insert_sorted(input logic signed [PRIO_W-1:0] prio,
                                         input logic [PAYLOAD_W-1:0] payload);
      int                  pos;
      bspq_pkg::entry_type e;
      pos = 0;
      e.prio    = prio;
      e.payload = payload;
      if (sorted_store.size() >= STORE_DEPTH) return;
      while (pos < sorted_store.size() && sorted_store[pos].prio <= prio) pos++;
      sorted_store.insert(pos, e);
   endfunction

   // Completions caused by one accepted request
   function automatic void predict_completions(input bspq_pkg::op_type op,
                                               input logic [TAG_W-1:0] tag,
                                               input logic signed [PRIO_W-1:0] prio,
                                               input logic [PAYLOAD_W-1:0] payload);
      int                       effective;
      bspq_pkg::entry_type      taken;
      bspq_pkg::waiter_put_type w;
      step_results.delete();
      effective = (capacity_reg == 0 || capacity_reg > STORE_DEPTH) ? STORE_DEPTH
                                                                    : int'(capacity_reg);
      if (op == bspq_pkg::OP_PUT) begin
         if (sorted_store.size() >= effective) begin
            if (parked_puts.size() >= WAITER_DEPTH) begin
               note_completion(tag, bspq_pkg::KIND_REJECT, '0);
            end else begin
               w.tag           = tag;
               w.entry.prio    = prio;
               w.entry.payload = payload;
               parked_puts.push_back(w);
            end
         end else begin
            insert_sorted(prio, payload);
            note_completion(tag, bspq_pkg::KIND_PUT_DONE, '0);
            // hand-off to the oldest parked get
            if (parked_gets.size() > 0 && sorted_store.size() > 0) begin
               taken = sorted_store.pop_front();
               note_completion(parked_gets.pop_front(), bspq_pkg::KIND_GET_DONE,
                               taken.payload);
            end
         end
      end else if (sorted_store.size() > 0) begin
         taken = sorted_store.pop_front();
         note_completion(tag, bspq_pkg::KIND_GET_DONE, taken.payload);
         // refill from the oldest parked put, capacity not consulted
         if (parked_puts.size() > 0) begin
            w = parked_puts.pop_front();
            insert_sorted(w.entry.prio, w.entry.payload);
            note_completion(w.tag, bspq_pkg::KIND_PUT_DONE, '0);
         end
      end else if (parked_gets.size() >= WAITER_DEPTH) begin
         note_completion(tag, bspq_pkg::KIND_REJECT, '0);
      end else begin
         parked_gets.push_back(tag);
      end
      foreach (step_results[k]) begin
         step_results[k].count = COUNT_W'(sorted_store.size());
         step_results[k].last  = (k == step_results.size() - 1);
      end
   endfunction

   // Monitor: predict on accepted requests, check accepted completions
   always @(posedge clock) begin
      completion_type got;
      completion_type exp;
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;

         if (csr_ch.valid && csr_ch.ready) capacity_reg = csr_ch.capacity_limit;

         if (req_ch.valid && req_ch.ready) begin
            predict_completions(bspq_pkg::op_type'(req_ch.operation), req_ch.requester_tag,
                                req_ch.entry_priority, req_ch.entry_payload);
            if (fixed_active)
               pending_completions.push_back(fixed_exp);
            else
               foreach (step_results[k]) pending_completions.push_back(step_results[k]);
         end

         if (rsp_ch.valid && rsp_ch.ready) begin
            got.tag     = rsp_ch.done_tag;
            got.kind    = bspq_pkg::done_kind_type'(rsp_ch.done_kind);
            got.payload = rsp_ch.delivered_payload;
            got.count   = rsp_ch.stored_count;
            got.last    = rsp_ch.last_of_run;
            if (pending_completions.size() == 0) begin
               $error("completion with nothing expected: tag %0h kind %0d", got.tag, got.kind);
               error_count++;
            end else begin
               exp = pending_completions.pop_front();
               if (got.tag !== exp.tag) begin
                  $error("done_tag: expected %0h, actual %0h", exp.tag, got.tag);
                  error_count++;
               end
               if (got.kind !== exp.kind) begin
                  $error("done_kind: expected %0d, actual %0d", exp.kind, got.kind);
                  error_count++;
               end
               if (got.payload !== exp.payload) begin
                  $error("delivered_payload: expected %0h, actual %0h", exp.payload,
                         got.payload);
                  error_count++;
               end
               if (got.count !== exp.count) begin
                  $error("stored_count: expected %0d, actual %0d", exp.count, got.count);
                  error_count++;
               end
               if (got.last !== exp.last) begin
                  $error("last_of_run: expected %0b, actual %0b", exp.last, got.last);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog on cycles without any handshake
   initial begin
      while (idle_cycles < WATCHDOG_MAX) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // Completion backpressure: short runs, short stalls, now and then a long one
   initial begin
      int run_left;
      int stall_left;
      run_left   = 0;
      stall_left = 0;
      rsp_ch.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (rsp_steady) begin
            rsp_ch.ready = 1'b1;
         end else if (run_left > 0) begin
            rsp_ch.ready = 1'b1;
            run_left--;
         end else if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready = 1'b1;
            run_left   = $urandom_range(0, 9);
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 3);
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 9);
      if (req_steady || roll < 6) return 0;
      if (roll < 9) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Drive one request from a falling edge, return at the falling edge after acceptance
   task automatic send_request(input bspq_pkg::op_type op, input logic [TAG_W-1:0] tag,
                               input logic signed [PRIO_W-1:0] prio,
                               input logic [PAYLOAD_W-1:0] payload);
      req_ch.operation      = op;
      req_ch.requester_tag  = tag;
      req_ch.entry_priority = prio;
      req_ch.entry_payload  = payload;
      req_ch.valid          = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic pause_requests(input int cycles);
      if (cycles > 0) begin
         req_ch.valid = 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // Capacity writes only with the block idle
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      req_ch.valid = 1'b0;
      while (pending_completions.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
      @(negedge clock);
      csr_ch.capacity_limit = value;
      csr_ch.valid          = 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   function automatic void add_row(input row_kind_type kind, input bspq_pkg::op_type op,
                                   input logic [TAG_W-1:0] tag, input int prio,
                                   input int prio_step, input logic [PAYLOAD_W-1:0] payload,
                                   input int reps, input bspq_pkg::done_kind_type exp_kind,
                                   input logic [COUNT_W-1:0] exp_count);
      stim_row_type r;
      r.kind      = kind;
      r.op        = op;
      r.tag       = tag;
      r.prio      = prio;
      r.prio_step = prio_step;
      r.payload   = payload;
      r.reps      = reps;
      r.exp_kind  = exp_kind;
      r.exp_count = exp_count;
      stim_table.push_back(r);
   endfunction

   // Stimulus
   initial begin
      stim_row_type             row;
      logic signed [PRIO_W-1:0] p;
      bspq_pkg::op_type         op;
      int                       sent;
      int                       burst;
      int                       put_pct;

      req_ch.valid          = 1'b0;
      req_ch.operation      = bspq_pkg::OP_PUT;
      req_ch.requester_tag  = '0;
      req_ch.entry_priority = '0;
      req_ch.entry_payload  = '0;
      csr_ch.valid          = 1'b0;
      csr_ch.capacity_limit = '0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // get parks on the empty store, next put hands its entry over
      add_row(ROW_REQ,   bspq_pkg::OP_GET, 8'h01, 0,      0, 32'h0,        1,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(0));
      add_row(ROW_REQ,   bspq_pkg::OP_PUT, 8'h02, -32768, 0, 32'hFFFFFFFF, 1,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(0));
      add_row(ROW_FIXED, bspq_pkg::OP_PUT, 8'hFF, 32767,  0, 32'h0,        1,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(1));
      // tie on the top priority, then the extremes and a middle value
      add_row(ROW_REQ,   bspq_pkg::OP_PUT, 8'h10, 32767,  0, 32'hA5A5A5A5, 1,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(0));
      add_row(ROW_REQ,   bspq_pkg::OP_PUT, 8'h11, -32768, 0, 32'h12345678, 1,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(0));
      add_row(ROW_REQ,   bspq_pkg::OP_PUT, 8'h12, 0,      0, 32'h5A5A5A5A, 1,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(0));
      add_row(ROW_REQ,   bspq_pkg::OP_GET, 8'h20, 0,      0, 32'h0,        4,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(0));
      // fill the get waiter queue (priority and payload bits ignored), then overflow it
      add_row(ROW_REQ,   bspq_pkg::OP_GET, 8'h40, 32767,  0, 32'hFFFFFFFF, 16,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(0));
      add_row(ROW_FIXED, bspq_pkg::OP_GET, 8'hEE, -1,     0, 32'hFFFFFFFF, 1,
              bspq_pkg::KIND_REJECT, COUNT_W'(0));
      add_row(ROW_REQ,   bspq_pkg::OP_PUT, 8'h00, -100,  25, 32'hC0DE0000, 16,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(0));
      // capacity one: fill the put waiter queue, then overflow it
      add_row(ROW_CSR,   bspq_pkg::OP_PUT, 8'h00, 0,      0, 32'd1,        1,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(0));
      add_row(ROW_FIXED, bspq_pkg::OP_PUT, 8'h50, 5,      0, 32'h0BADF00D, 1,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(1));
      add_row(ROW_REQ,   bspq_pkg::OP_PUT, 8'h60, 300,  -40, 32'h60000000, 16,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(0));
      add_row(ROW_FIXED, bspq_pkg::OP_PUT, 8'hEF, 7,      0, 32'hDEADBEEF, 1,
              bspq_pkg::KIND_REJECT, COUNT_W'(1));
      // capacity above depth saturates; parked puts move in only on gets
      add_row(ROW_CSR,   bspq_pkg::OP_PUT, 8'h00, 0,      0, 32'd31,       1,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(0));
      add_row(ROW_REQ,   bspq_pkg::OP_GET, 8'h70, 0,      0, 32'h0,        4,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(0));
      add_row(ROW_REQ,   bspq_pkg::OP_PUT, 8'h80, 1000, -333, 32'h80000000, 6,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(0));
      // capacity lowered below the count
      add_row(ROW_CSR,   bspq_pkg::OP_PUT, 8'h00, 0,      0, 32'd2,        1,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(0));
      add_row(ROW_REQ,   bspq_pkg::OP_PUT, 8'h90, -2,     0, 32'h90000000, 2,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(0));
      add_row(ROW_REQ,   bspq_pkg::OP_GET, 8'hA0, 0,      0, 32'h0,        24,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(0));
      // back to full depth: hand-offs, then a full store and one parked put
      add_row(ROW_CSR,   bspq_pkg::OP_PUT, 8'h00, 0,      0, 32'd0,        1,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(0));
      add_row(ROW_REQ,   bspq_pkg::OP_PUT, 8'hC0, -1,     0, 32'hC0000000, 20,
              bspq_pkg::KIND_PUT_DONE, COUNT_W'(0));

      foreach (stim_table[n]) begin
         row = stim_table[n];
         if (row.kind == ROW_CSR) begin
            write_capacity(row.payload[CAP_W-1:0]);
         end else begin
            for (int i = 0; i < row.reps; i++) begin
               fixed_active      = (row.kind == ROW_FIXED);
               fixed_exp.tag     = row.tag + TAG_W'(i);
               fixed_exp.kind    = row.exp_kind;
               fixed_exp.payload = '0;
               fixed_exp.count   = row.exp_count;
               fixed_exp.last    = 1'b1;
               send_request(row.op, row.tag + TAG_W'(i), PRIO_W'(row.prio + i * row.prio_step),
                            row.payload + PAYLOAD_W'(i));
               fixed_active = 1'b0;
               pause_requests(pick_gap());
            end
         end
      end

      // Random phases: a capacity setting, a request mix, a backpressure style
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       write_capacity(CAP_W'(0));
            1:       write_capacity(CAP_W'(1));
            2:       write_capacity(CAP_W'(2));
            3:       write_capacity(CAP_W'(STORE_DEPTH));
            4:       write_capacity(CAP_W'($urandom_range(17, 31)));
            default: write_capacity(CAP_W'($urandom_range(3, 15)));
         endcase
         case ($urandom_range(0, 2))
            0:       put_pct = 25;
            1:       put_pct = 50;
            default: put_pct = 75;
         endcase
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         burst = $urandom_range(20, 60);
         for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
            op = ($urandom_range(0, 99) < put_pct) ? bspq_pkg::OP_PUT : bspq_pkg::OP_GET;
            case ($urandom_range(0, 9))
               0:       p = 16'sh8000;
               1:       p = 16'sh7FFF;
               2, 3, 4: p = PRIO_W'(int'($urandom_range(0, 4)) - 2);
               default: p = PRIO_W'($urandom);
            endcase
            send_request(op, TAG_W'($urandom_range(0, 255)), p, $urandom);
            sent++;
            pause_requests(pick_gap());
         end
      end

      // Drain and settle
      req_ch.valid = 1'b0;
      rsp_steady   = 1'b0;
      while (pending_completions.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
